// ----- hdl/cfla_pkg.sv -----
// Shared types and constants of the cell free-list allocator.
// No dependencies; cfla_if and the allocator top import this package.
package cfla_pkg;

   localparam int CELL_W  = 10;
   localparam int COUNT_W = 11;

   localparam logic [CELL_W-1:0]  FREE_MAX = {CELL_W{1'b1}};
   localparam logic [COUNT_W-1:0] USED_MAX = {COUNT_W{1'b1}};

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINK,
      ST_FINISH
   } state_type;

endpackage

// ----- hdl/cfla_if.sv -----
// Valid/ready channel interfaces for the request and response transactions.
// Depends on cfla_pkg for field widths.
interface cfla_req_if import cfla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [CELL_W-1:0] cell_index;

   modport source (output valid, operation, cell_index, input ready);
   modport sink   (input valid, operation, cell_index, output ready);
endinterface

interface cfla_rsp_if import cfla_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [CELL_W-1:0]  cell_out;
   logic [CELL_W-1:0]  free_total;
   logic [COUNT_W-1:0] used_total;
   logic [COUNT_W-1:0] used_peak;

   modport source (output valid, status, cell_out, free_total, used_total, used_peak,
                   input ready);
   modport sink   (input valid, status, cell_out, free_total, used_total, used_peak,
                   output ready);
endinterface

// ----- hdl/cfla_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module cfla_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/cell_free_list_allocator_top.sv -----
// Cell free-list allocator: a pool of CELLS cells kept as a free list and a used
// ring anchored at cell 0. A transaction is accepted together with its link
// read in ST_IDLE, then two write pairs into the next/back link RAMs follow in
// ST_LINK and ST_FINISH, since each RAM has a single write port. After reset a
// clearing pass writes every cell of the link RAMs; no request is accepted until it ends.
// Depends on cfla_pkg, cfla_if and cfla_ram.
module cell_free_list_allocator_top import cfla_pkg::*; #(
   parameter int CELLS = 1024
) (
   input logic        clock,
   input logic        reset,
   cfla_req_if.sink   req_ch,
   cfla_rsp_if.source rsp_ch
);

   localparam int LW = $clog2(CELLS);
   localparam int IW = (LW > CELL_W) ? LW : CELL_W;

   localparam logic [LW-1:0]       LAST_CELL  = LW'(CELLS - 1);
   localparam logic [LW:0]         CELLS_L    = (LW + 1)'(CELLS);
   localparam logic [IW:0]         CELLS_I    = (IW + 1)'(CELLS);
   localparam logic [CELL_W-1:0]   FREE_RESET = CELL_W'(CELLS - 1);

   state_type          state_ff, state_in;
   logic [LW-1:0]      clr_ff;
   logic [LW-1:0]      anchor_ff;
   logic [LW-1:0]      free_head_ff, free_head_in;
   logic [CELL_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [COUNT_W-1:0] used_cnt_ff, used_cnt_in;
   logic [COUNT_W-1:0] peak_ff, peak_in;
   logic               op_ff;
   logic [IW-1:0]      idx_ff;
   status_type         res_status_ff, res_status_in;
   logic [CELL_W-1:0]  res_cell_ff, res_cell_in;
   logic               wr2_en_ff, wr2_en_in;
   logic [LW-1:0]      wr2_next_addr_ff, wr2_next_addr_in;
   logic [LW-1:0]      wr2_next_data_ff, wr2_next_data_in;
   logic [LW-1:0]      wr2_back_addr_ff, wr2_back_addr_in;
   logic [LW-1:0]      wr2_back_data_ff, wr2_back_data_in;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [CELL_W-1:0]  rsp_cell_ff;
   logic [CELL_W-1:0]  rsp_free_ff;
   logic [COUNT_W-1:0] rsp_used_ff;
   logic [COUNT_W-1:0] rsp_peak_ff;

   logic               next_we, back_we;
   logic [LW-1:0]      next_waddr, next_wdata, next_raddr, next_rdata;
   logic [LW-1:0]      back_waddr, back_wdata, back_raddr, back_rdata;

   logic               req_accept;
   logic               load_rsp;
   logic [IW-1:0]      req_idx;
   logic [LW-1:0]      p_cell;
   logic [COUNT_W-1:0] used_inc;

   assign req_idx    = IW'(req_ch.cell_index);
   assign req_accept = req_ch.valid && req_ch.ready;
   assign p_cell     = free_head_ff;
   assign used_inc   = (used_cnt_ff < USED_MAX) ? used_cnt_ff + 1'b1 : USED_MAX;

   cfla_ram #(.DEPTH(CELLS), .WIDTH(LW)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (next_raddr),
      .rd_data (next_rdata)
   );

   cfla_ram #(.DEPTH(CELLS), .WIDTH(LW)) u_back_ram (
      .clock   (clock),
      .wr_en   (back_we),
      .wr_addr (back_waddr),
      .wr_data (back_wdata),
      .rd_addr (back_raddr),
      .rd_data (back_rdata)
   );

   always_comb begin
      state_in         = state_ff;
      free_head_in     = free_head_ff;
      free_cnt_in      = free_cnt_ff;
      used_cnt_in      = used_cnt_ff;
      peak_in          = peak_ff;
      res_status_in    = res_status_ff;
      res_cell_in      = res_cell_ff;
      wr2_en_in        = wr2_en_ff;
      wr2_next_addr_in = wr2_next_addr_ff;
      wr2_next_data_in = wr2_next_data_ff;
      wr2_back_addr_in = wr2_back_addr_ff;
      wr2_back_data_in = wr2_back_data_ff;
      req_ch.ready     = 1'b0;
      load_rsp         = 1'b0;
      next_we          = 1'b0;
      next_waddr       = '0;
      next_wdata       = '0;
      back_we          = 1'b0;
      back_waddr       = '0;
      back_wdata       = '0;
      next_raddr       = (op_type'(req_ch.operation) == OP_ALLOC) ? free_head_ff
                                                                  : req_idx[LW-1:0];
      back_raddr       = req_idx[LW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            next_we    = 1'b1;
            next_waddr = clr_ff;
            next_wdata = (clr_ff == '0 || clr_ff == LAST_CELL) ? '0 : clr_ff + 1'b1;
            back_we    = 1'b1;
            back_waddr = clr_ff;
            back_wdata = '0;
            if (clr_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            state_in      = ST_FINISH;
            wr2_en_in     = 1'b0;
            res_cell_in   = '0;
            res_status_in = STATUS_DONE;
            if (op_type'(op_ff) == OP_ALLOC) begin
               if (p_cell == '0 || {1'b0, p_cell} >= CELLS_L || next_rdata == '0) begin
                  res_status_in = STATUS_EXHAUSTED;
               end else begin
                  next_we          = 1'b1;
                  next_waddr       = p_cell;
                  next_wdata       = anchor_ff;
                  back_we          = 1'b1;
                  back_waddr       = p_cell;
                  back_wdata       = '0;
                  free_head_in     = next_rdata;
                  free_cnt_in      = (free_cnt_ff != '0) ? free_cnt_ff - 1'b1 : '0;
                  used_cnt_in      = used_inc;
                  peak_in          = (used_inc > peak_ff) ? used_inc : peak_ff;
                  wr2_en_in        = 1'b1;
                  wr2_next_addr_in = '0;
                  wr2_next_data_in = p_cell;
                  wr2_back_addr_in = anchor_ff;
                  wr2_back_data_in = p_cell;
                  res_cell_in      = IW'(p_cell) >> 0 == '0 ? '0 : CELL_W'(IW'(p_cell));
               end
            end else begin
               if (idx_ff == '0 || {1'b0, idx_ff} >= CELLS_I) begin
                  res_status_in = STATUS_BAD_INDEX;
               end else begin
                  next_we          = 1'b1;
                  next_waddr       = back_rdata;
                  next_wdata       = next_rdata;
                  back_we          = 1'b1;
                  back_waddr       = next_rdata;
                  back_wdata       = back_rdata;
                  free_head_in     = idx_ff[LW-1:0];
                  free_cnt_in      = (free_cnt_ff < FREE_MAX) ? free_cnt_ff + 1'b1 : FREE_MAX;
                  used_cnt_in      = (used_cnt_ff != '0) ? used_cnt_ff - 1'b1 : '0;
                  wr2_en_in        = 1'b1;
                  wr2_next_addr_in = idx_ff[LW-1:0];
                  wr2_next_data_in = free_head_ff;
                  wr2_back_addr_in = idx_ff[LW-1:0];
                  wr2_back_data_in = '0;
                  res_cell_in      = idx_ff[CELL_W-1:0];
               end
            end
         end
         ST_FINISH: begin
            next_we    = wr2_en_ff;
            next_waddr = wr2_next_addr_ff;
            next_wdata = wr2_next_data_ff;
            back_we    = wr2_en_ff;
            back_waddr = wr2_back_addr_ff;
            back_wdata = wr2_back_data_ff;
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         anchor_ff    <= '0;
         free_head_ff <= LW'(1);
         free_cnt_ff  <= FREE_RESET;
         used_cnt_ff  <= COUNT_W'(1);
         peak_ff      <= '0;
         wr2_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         used_cnt_ff  <= used_cnt_in;
         peak_ff      <= peak_in;
         wr2_en_ff    <= wr2_en_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         // mirror of next_link[0]
         if (next_we && next_waddr == '0) begin
            anchor_ff <= next_wdata;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff  <= req_ch.operation;
         idx_ff <= req_idx;
      end
      res_status_ff    <= res_status_in;
      res_cell_ff      <= res_cell_in;
      wr2_next_addr_ff <= wr2_next_addr_in;
      wr2_next_data_ff <= wr2_next_data_in;
      wr2_back_addr_ff <= wr2_back_addr_in;
      wr2_back_data_ff <= wr2_back_data_in;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_cell_ff   <= res_cell_ff;
         rsp_free_ff   <= free_cnt_ff;
         rsp_used_ff   <= used_cnt_ff;
         rsp_peak_ff   <= peak_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.cell_out   = rsp_cell_ff;
   assign rsp_ch.free_total = rsp_free_ff;
   assign rsp_ch.used_total = rsp_used_ff;
   assign rsp_ch.used_peak  = rsp_peak_ff;

`ifndef NO_ASSERTIONS
   a_accept_to_link: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_LINK)
      else $error("accepted transaction did not enter link update");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !next_we && !back_we)
      else $error("link RAM written while idle");

   a_refused_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != STATUS_DONE |-> rsp_ch.cell_out == '0)
      else $error("refused transaction reports a cell");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish state");
`endif

endmodule
